/* hdl/http_response_length_framer_macros.svh */
// ----------------------------------------------------------------------------
// http_response_length_framer_macros
// assertion macros used by the framer back end (hrlf_back)
// ----------------------------------------------------------------------------
`ifndef HTTP_RESPONSE_LENGTH_FRAMER_MACROS_SVH
`define HTTP_RESPONSE_LENGTH_FRAMER_MACROS_SVH

`ifndef SYNTH
`define HRLF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define HRLF_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define HRLF_ASSERT(name, prop, msg)
`define HRLF_ASSERT_NEVER(name, cond, msg)
`endif

`endif

/* hdl/hrlf_pkg.sv */
// ----------------------------------------------------------------------------
// hrlf_pkg
// types and constants of the http response length framer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hrlf_pkg;

  localparam int LengthBits = 32;
  localparam logic [LengthBits-1:0] LenMax = {LengthBits{1'b1}};

  localparam int NameLen = 15;
  localparam int EndLen = 4;
  localparam logic [NameLen*8-1:0] FieldName = "Content-Length:";
  localparam logic [EndLen*8-1:0] BlankLine = {8'h0d, 8'h0a, 8'h0d, 8'h0a};

  localparam int NameIdxW = $clog2(NameLen + 1);
  localparam int NameSelW = $clog2(NameLen);
  localparam int EndIdxW = $clog2(EndLen + 1);
  localparam int EndSelW = $clog2(EndLen);

  localparam logic [7:0] CharCr = 8'h0d;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW = $clog2(QueueDepth);
  localparam int QueueCntW = $clog2(QueueDepth + 1);

  localparam int OutDepth = 2;
  localparam int OutCntW = $clog2(OutDepth + 1);

  typedef enum logic [1:0] {
    PhHeader,
    PhSpaces,
    PhDigits,
    PhBody
  } phase_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       restart;
  } in_word_t;

  typedef struct packed {
    logic        message_done;
    logic        length_error;
    logic [31:0] message_length;
  } out_word_t;

  typedef struct packed {
    logic               restart;
    logic               is_cr;
    logic               is_space;
    logic               is_digit;
    logic [3:0]         digit;
    logic [NameLen-1:0] name_eq;
    logic [EndLen-1:0]  end_eq;
  } cls_t;

endpackage

`default_nettype wire

/* hdl/hrlf_front.sv */
// ----------------------------------------------------------------------------
// hrlf_front
// classifies each received byte as cr, space or digit and against the field name and the blank line
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hrlf_front (
  input  hrlf_pkg::in_word_t word_i,
  output hrlf_pkg::cls_t     cls_o
);
  import hrlf_pkg::*;

  logic [7:0] b;
  logic [7:0] b_off;

  assign b = word_i.rx_byte;
  assign b_off = b - CharZero;

  always_comb begin
    cls_o.restart  = word_i.restart;
    cls_o.is_cr    = (b == CharCr);
    cls_o.is_space = (b == CharSpace);
    cls_o.is_digit = (b >= CharZero) && (b <= CharNine);
    cls_o.digit    = b_off[3:0];
    for (int k = 0; k < NameLen; k++) begin
      cls_o.name_eq[k] = (b == FieldName[(NameLen-1-k)*8 +: 8]);
    end
    for (int k = 0; k < EndLen; k++) begin
      cls_o.end_eq[k] = (b == BlankLine[(EndLen-1-k)*8 +: 8]);
    end
  end

endmodule

`default_nettype wire

/* hdl/hrlf_queue.sv */
// ----------------------------------------------------------------------------
// hrlf_queue
// short first-word-fall-through queue between the classifier and the counter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hrlf_queue (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            push_i,
  input  hrlf_pkg::cls_t word_i,
  output logic           full_o,
  input  wire            pop_i,
  output hrlf_pkg::cls_t word_o,
  output logic           empty_o
);
  import hrlf_pkg::*;

  cls_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, wr_d;
  logic [QueuePtrW-1:0] rd_q, rd_d;
  logic [QueueCntW-1:0] cnt_q, cnt_d;
  logic                 do_push;
  logic                 do_pop;

  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign word_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= word_i;
    end
  end

endmodule

`default_nettype wire

/* hdl/hrlf_back.sv */
// ----------------------------------------------------------------------------
// hrlf_back
// header and body counting, length field parsing and result buffering
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "http_response_length_framer_macros.svh"

module hrlf_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  hrlf_pkg::cls_t      cls_i,
  input  wire                 cls_empty_i,
  output logic                cls_pop_o,
  output hrlf_pkg::out_word_t out_word_o,
  output logic                empty,
  input  wire                 pop
);
  import hrlf_pkg::*;

  typedef struct packed {
    logic emit;
    logic err;
    logic to_body;
    logic to_spaces;
    logic to_digits;
    logic to_header;
  } step_t;

  phase_e                phase_q, phase_d, ph;
  logic [NameIdxW-1:0]   name_idx_q, name_idx_d, nidx, nidx_next;
  logic [EndIdxW-1:0]    end_idx_q, end_idx_d, eidx, eidx_next;
  logic                  seen_q, seen_d, seen;
  logic [LengthBits-1:0] len_q, len_d, len;
  logic [LengthBits-1:0] hdr_q, hdr_d, hdr, hdr_inc;
  logic [LengthBits-1:0] body_q, body_d, body;
  logic [LengthBits-1:0] total_q, total_d;
  logic [LengthBits:0]   sum;
  logic [LengthBits+3:0] len_x10;
  logic                  take;
  step_t                 st;
  logic [LengthBits-1:0] res_len;

  out_word_t             out_mem_q [OutDepth];
  logic                  out_wr_q, out_rd_q;
  logic [OutCntW-1:0]    out_cnt_q;
  logic                  res_push;
  logic                  out_pop;
  out_word_t             res_word;

  assign take      = !cls_empty_i && (out_cnt_q != OutCntW'(OutDepth));
  assign cls_pop_o = take;

  // restart drops the partial message before the word is used
  always_comb begin
    if (cls_i.restart) begin
      ph   = PhHeader;
      nidx = '0;
      eidx = '0;
      seen = 1'b0;
      len  = '0;
      hdr  = '0;
      body = '0;
    end else begin
      ph   = phase_q;
      nidx = name_idx_q;
      eidx = end_idx_q;
      seen = seen_q;
      len  = len_q;
      hdr  = hdr_q;
      body = body_q;
    end
  end

  assign hdr_inc = hdr + 1'b1;
  assign sum     = {1'b0, hdr} + {1'b0, len} + 1'b1;
  assign len_x10 = ({4'b0, len} << 3) + ({4'b0, len} << 1) + (LengthBits+4)'(cls_i.digit);

  always_comb begin
    eidx_next = cls_i.end_eq[eidx[EndSelW-1:0]] ? eidx + 1'b1 : EndIdxW'(cls_i.is_cr);
    nidx_next = cls_i.name_eq[nidx[NameSelW-1:0]] ? nidx + 1'b1
                                                  : NameIdxW'(cls_i.name_eq[0]);
  end

  // step decode and data registers
  always_comb begin
    st         = '0;
    res_len    = '0;
    name_idx_d = name_idx_q;
    end_idx_d  = end_idx_q;
    seen_d     = seen_q;
    len_d      = len_q;
    hdr_d      = hdr_q;
    body_d     = body_q;
    total_d    = total_q;
    if (take) begin
      name_idx_d = nidx;
      end_idx_d  = eidx;
      seen_d     = seen;
      len_d      = len;
      hdr_d      = hdr;
      body_d     = body;
      if (ph == PhBody) begin
        body_d = body - 1'b1;
        if (body == LengthBits'(1)) begin
          st.emit = 1'b1;
          res_len = total_q;
        end
      end else if (hdr == LenMax) begin
        st.emit = 1'b1;
        st.err  = 1'b1;
      end else begin
        hdr_d = hdr_inc;
        if (ph == PhHeader) begin
          if (eidx_next == EndIdxW'(EndLen)) begin
            if (!seen || len == '0) begin
              st.emit = 1'b1;
              res_len = hdr_inc;
            end else if (sum[LengthBits]) begin
              st.emit = 1'b1;
              st.err  = 1'b1;
            end else begin
              st.to_body = 1'b1;
              body_d     = len;
              total_d    = sum[LengthBits-1:0];
              name_idx_d = '0;
              end_idx_d  = '0;
            end
          end else begin
            end_idx_d = eidx_next;
            if (!seen) begin
              if (nidx_next == NameIdxW'(NameLen)) begin
                name_idx_d   = '0;
                st.to_spaces = 1'b1;
              end else begin
                name_idx_d = nidx_next;
              end
            end
          end
        end else begin
          end_idx_d = '0;
          if (cls_i.is_cr) begin
            seen_d       = 1'b1;
            end_idx_d    = EndIdxW'(1);
            st.to_header = 1'b1;
          end else if (ph == PhSpaces && cls_i.is_space) begin
            st.to_header = 1'b0;
          end else if (cls_i.is_digit) begin
            st.to_digits = 1'b1;
            if (|len_x10[LengthBits+3:LengthBits]) begin
              st.emit = 1'b1;
              st.err  = 1'b1;
            end else begin
              len_d = len_x10[LengthBits-1:0];
            end
          end else begin
            st.emit = 1'b1;
            st.err  = 1'b1;
          end
        end
      end
      if (st.emit) begin
        name_idx_d = '0;
        end_idx_d  = '0;
        seen_d     = 1'b0;
        len_d      = '0;
        hdr_d      = '0;
        body_d     = '0;
      end
    end
  end

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (take) begin
      if (st.emit) begin
        phase_d = PhHeader;
      end else if (st.to_body) begin
        phase_d = PhBody;
      end else if (st.to_spaces) begin
        phase_d = PhSpaces;
      end else if (st.to_digits) begin
        phase_d = PhDigits;
      end else if (st.to_header) begin
        phase_d = PhHeader;
      end else begin
        phase_d = ph;
      end
    end
  end

  // result word
  always_comb begin
    res_push                = take && st.emit;
    res_word.message_done   = !st.err;
    res_word.length_error   = st.err;
    res_word.message_length = st.err ? 32'd0 : 32'(res_len);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhHeader;
      name_idx_q <= '0;
      end_idx_q  <= '0;
      seen_q     <= 1'b0;
      len_q      <= '0;
      hdr_q      <= '0;
      body_q     <= '0;
      total_q    <= '0;
    end else begin
      phase_q    <= phase_d;
      name_idx_q <= name_idx_d;
      end_idx_q  <= end_idx_d;
      seen_q     <= seen_d;
      len_q      <= len_d;
      hdr_q      <= hdr_d;
      body_q     <= body_d;
      total_q    <= total_d;
    end
  end

  // result buffer
  assign empty      = (out_cnt_q == '0);
  assign out_pop    = pop && !empty;
  assign out_word_o = out_mem_q[out_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_wr_q  <= 1'b0;
      out_rd_q  <= 1'b0;
      out_cnt_q <= '0;
    end else begin
      if (res_push) begin
        out_wr_q <= !out_wr_q;
      end
      if (out_pop) begin
        out_rd_q <= !out_rd_q;
      end
      if (res_push && !out_pop) begin
        out_cnt_q <= out_cnt_q + 1'b1;
      end else if (out_pop && !res_push) begin
        out_cnt_q <= out_cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      out_mem_q[out_wr_q] <= res_word;
    end
  end

  `HRLF_ASSERT(a_body_nonzero, (phase_q == PhBody) |-> (body_q != '0), "body count at zero")
  `HRLF_ASSERT(a_field_idx_clear, (phase_q == PhSpaces || phase_q == PhDigits) |-> (end_idx_q == '0 && name_idx_q == '0), "match index left set in length field")
  `HRLF_ASSERT_NEVER(a_out_overflow, out_cnt_q > OutCntW'(OutDepth), "result buffer overflow")
  `HRLF_ASSERT(a_emit_clears, res_push |=> (phase_q == PhHeader && hdr_q == '0 && !seen_q), "message state not cleared after result")

endmodule

`default_nettype wire

/* hdl/http_response_length_framer.sv */
// ----------------------------------------------------------------------------
// http_response_length_framer
// frames http responses by header size and content length
// ----------------------------------------------------------------------------
// throughput: one byte per cycle while the result buffer is not full, set by the counter update
// a byte is registered in the queue, then its result in the result buffer, from which it is popped
// a four-word queue lets the classifier and the counter stall apart
// reset: asynchronous, active low, clears all message state and both queues
`timescale 1ns / 1ps
`default_nettype none

module http_response_length_framer (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push,
  input  hrlf_pkg::in_word_t  in_word_i,
  output logic                full,
  output logic                empty,
  input  wire                 pop,
  output hrlf_pkg::out_word_t out_word_o
);
  import hrlf_pkg::*;

  cls_t cls_in;
  cls_t cls_head;
  logic cls_empty;
  logic cls_pop;

  hrlf_front u_front (
    .word_i (in_word_i),
    .cls_o  (cls_in)
  );

  hrlf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .word_i  (cls_in),
    .full_o  (full),
    .pop_i   (cls_pop),
    .word_o  (cls_head),
    .empty_o (cls_empty)
  );

  hrlf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cls_i       (cls_head),
    .cls_empty_i (cls_empty),
    .cls_pop_o   (cls_pop),
    .out_word_o  (out_word_o),
    .empty       (empty),
    .pop         (pop)
  );

endmodule

`default_nettype wire

/* dv/hrlf_frame_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlf_frame_checker
// watches both queue ports of the framer, predicts the framing of each byte
// word and compares every popped result word, field by field, in order
// ----------------------------------------------------------------------------

module hrlf_frame_checker
  import hrlf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  logic      full_i,
  input  in_word_t  in_word_i,
  input  logic      pop_i,
  input  logic      empty_i,
  input  out_word_t out_word_i,
  output int        pending_o,
  output int        mismatches_o
);

  localparam logic [63:0] LenLimit = 64'(LenMax);

  out_word_t expected_words[$];
  out_word_t want;

  phase_e              frame_phase;
  logic [NameIdxW-1:0] name_pos;
  logic [EndIdxW-1:0]  blank_pos;
  logic                len_seen;
  logic [63:0]         len_value;
  logic [63:0]         hdr_count;
  logic [63:0]         body_left;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("%0t: %s: got %0h expected %0h", $time, what, got, exp_val);
    mismatches_o++;
  endtask

  function automatic logic [7:0] name_char(input int idx);
    return FieldName[(NameLen-1-idx)*8 +: 8];
  endfunction

  task automatic clear_message();
    frame_phase = PhHeader;
    name_pos = '0;
    blank_pos = '0;
    len_seen = 1'b0;
    len_value = '0;
    hdr_count = '0;
    body_left = '0;
  endtask

  task automatic expect_word(input logic done, input logic err, input logic [63:0] total);
    out_word_t w;
    w.message_done = done;
    w.length_error = err;
    w.message_length = err ? 32'd0 : total[31:0];
    expected_words.push_back(w);
    clear_message();
  endtask

  task automatic close_header();
    if (!len_seen || len_value == 0) begin
      expect_word(1'b1, 1'b0, hdr_count);
    end else if (len_value > LenLimit - hdr_count) begin
      expect_word(1'b0, 1'b1, '0);
    end else begin
      body_left = len_value;
      frame_phase = PhBody;
      name_pos = '0;
      blank_pos = '0;
    end
  endtask

  task automatic frame_byte(input in_word_t w);
    logic [7:0]  b;
    logic [63:0] d;
    b = w.rx_byte;
    if (w.restart) clear_message();
    if (frame_phase == PhBody) begin
      if (body_left > 0) body_left -= 1;
      if (body_left == 0) expect_word(1'b1, 1'b0, hdr_count + len_value);
      return;
    end
    if (hdr_count >= LenLimit) begin
      expect_word(1'b0, 1'b1, '0);
      return;
    end
    hdr_count += 1;
    if (frame_phase == PhHeader) begin
      if (blank_pos < EndLen && b == BlankLine[(EndLen-1-blank_pos)*8 +: 8]) blank_pos += 1;
      else blank_pos = (b == CharCr) ? 1 : 0;
      if (blank_pos >= EndLen) begin
        close_header();
        return;
      end
      if (!len_seen) begin
        if (name_pos < NameLen && b == name_char(name_pos)) name_pos += 1;
        else name_pos = (b == name_char(0)) ? 1 : 0;
        if (name_pos >= NameLen) begin
          name_pos = '0;
          frame_phase = PhSpaces;
        end
      end
      return;
    end
    // inside the length field
    blank_pos = '0;
    if (b == CharCr) begin
      len_seen = 1'b1;
      blank_pos = 1;
      frame_phase = PhHeader;
      return;
    end
    if (frame_phase == PhSpaces && b == CharSpace) return;
    if (b >= CharZero && b <= CharNine) begin
      frame_phase = PhDigits;
      d = 64'(b - CharZero);
      if (len_value > (LenLimit - d) / 10) expect_word(1'b0, 1'b1, '0);
      else len_value = len_value * 10 + d;
      return;
    end
    expect_word(1'b0, 1'b1, '0);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_words.delete();
      clear_message();
      pending_o <= 0;
    end else begin
      if (pop_i && !empty_i) begin
        if (expected_words.size() == 0) begin
          report_mismatch("result word with none expected", out_word_i.message_length, '0);
        end else begin
          want = expected_words.pop_front();
          if (out_word_i.message_done !== want.message_done)
            report_mismatch("message_done", 32'(out_word_i.message_done),
                            32'(want.message_done));
          if (out_word_i.length_error !== want.length_error)
            report_mismatch("length_error", 32'(out_word_i.length_error),
                            32'(want.length_error));
          if (out_word_i.message_length !== want.message_length)
            report_mismatch("message_length", out_word_i.message_length,
                            want.message_length);
        end
      end
      if (push_i && !full_i) frame_byte(in_word_i);
      pending_o <= expected_words.size();
    end
  end

endmodule

/* dv/http_response_length_framer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_response_length_framer_tb
// feeds response byte streams into the framer: a short directed set of
// framing corner cases, then random well-formed, malformed, cut and noisy
// messages, with bursty pushes and a patterned pop side; the checker
// predicts and compares every result word
// ----------------------------------------------------------------------------

module http_response_length_framer_tb;
  import hrlf_pkg::*;

  localparam int ItemTarget = 1700;
  localparam int CycleLimit = 200000;
  localparam logic [7:0] CharLf = 8'h0a;

  typedef enum logic [1:0] {PopAlways, PopCoin, PopSparse, PopToggle} pop_mode_e;
  typedef enum logic [2:0] {MsgSized, MsgUnsized, MsgBroken, MsgCut, MsgNoise} msg_kind_e;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push = 1'b0;
  logic      pop = 1'b0;
  in_word_t  in_word = '0;
  logic      full;
  logic      empty;
  out_word_t out_word;

  int   pending;
  int   mismatches;
  int   cycles = 0;
  int   sent = 0;
  int   burst_left = 8;
  logic restart_pending = 1'b0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  http_response_length_framer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .in_word_i  (in_word),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .out_word_o (out_word)
  );

  hrlf_frame_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_i       (full),
    .in_word_i    (in_word),
    .pop_i        (pop),
    .empty_i      (empty),
    .out_word_i   (out_word),
    .pending_o    (pending),
    .mismatches_o (mismatches)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("http_response_length_framer regression: fail");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    in_word_t w;
    w.rx_byte = b;
    w.restart = restart_pending;
    restart_pending = 1'b0;
    push <= 1'b1;
    in_word <= w;
    do @(posedge clk_i); while (full);
    sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_crlf();
    send_byte(CharCr);
    send_byte(CharLf);
  endtask

  task automatic send_filler_line();
    repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(8'h61, 8'h7a)));
    send_text(": ");
    repeat ($urandom_range(0, 8)) send_byte(8'($urandom_range(8'h20, 8'h7e)));
    send_crlf();
  endtask

  function automatic logic [7:0] bad_char();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0: c = 8'h09;
      1: c = "+";
      2: c = "-";
      default: begin
        do c = 8'($urandom_range(0, 255));
        while (c == CharSpace || c == CharCr || (c >= CharZero && c <= CharNine));
      end
    endcase
    return c;
  endfunction

  task automatic directed_cases();
    // no length field, empty field, zero length, short body with extreme bytes
    send_crlf();
    send_crlf();
    send_text("Content-Length:");
    send_crlf();
    send_crlf();
    send_text("Content-Length: 0");
    send_crlf();
    send_crlf();
    send_text("Content-Length:  3");
    send_crlf();
    send_crlf();
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h80);
    // bad characters and overflows
    send_text("Content-Length: +5");
    send_crlf();
    send_crlf();
    send_text("Content-Length:");
    send_byte(8'h09);
    send_crlf();
    send_crlf();
    send_text("Content-Length: 7 ");
    send_crlf();
    send_crlf();
    send_text("Content-Length:4294967296");
    send_crlf();
    send_crlf();
    send_text("Content-Length:4294967295");
    send_crlf();
    send_crlf();
    // repeated field
    send_text("Content-Length:2");
    send_crlf();
    send_text("Content-Length:7");
    send_crlf();
    send_crlf();
    send_text("ab");
    // restart inside a header and inside a long body
    send_text("Content-Le");
    restart_pending = 1'b1;
    send_crlf();
    send_crlf();
    send_text("Content-Length:4000000000");
    send_crlf();
    send_crlf();
    send_text("xyz");
    restart_pending = 1'b1;
    send_crlf();
    send_crlf();
  endtask

  task automatic random_message();
    msg_kind_e       kind;
    int              roll;
    int              lines;
    int              field_at;
    int              body_len;
    int              cut_at;
    longint unsigned big;
    roll = $urandom_range(0, 99);
    if (roll < 55) kind = MsgSized;
    else if (roll < 70) kind = MsgUnsized;
    else if (roll < 85) kind = MsgBroken;
    else if (roll < 93) kind = MsgCut;
    else kind = MsgNoise;
    if ($urandom_range(0, 9) == 0) restart_pending = 1'b1;

    if (kind == MsgNoise) begin
      repeat ($urandom_range(4, 30)) begin
        restart_pending = ($urandom_range(0, 15) == 0);
        case ($urandom_range(0, 3))
          0: send_byte(CharCr);
          1: send_byte(CharLf);
          default: send_byte(8'($urandom_range(0, 255)));
        endcase
      end
      restart_pending = 1'b1;
      return;
    end

    body_len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 200) : $urandom_range(0, 24);
    cut_at = $urandom_range(0, 2);
    if (kind == MsgCut && $urandom_range(0, 1)) body_len = $urandom_range(1000, 2000000000);
    if ($urandom_range(0, 1)) begin
      send_text("HTTP/1.1 200 OK");
      send_crlf();
    end
    lines = $urandom_range(0, 2);
    field_at = $urandom_range(0, lines);
    for (int i = 0; i <= lines; i++) begin
      if (i != field_at) begin
        send_filler_line();
      end else if (kind == MsgUnsized) begin
        case ($urandom_range(0, 3))
          0: send_text("content-length: 5");
          1: send_text("Content-Lengt: 5");
          2: send_text("Content-Length 5");
          default: send_text("Content-Len");
        endcase
        send_crlf();
      end else begin
        send_text("Content-Length:");
        repeat ($urandom_range(0, 3)) send_byte(CharSpace);
        if (kind == MsgBroken) begin
          case ($urandom_range(0, 4))
            0: begin
              send_byte(bad_char());
              send_text("5");
            end
            1: begin
              send_text($sformatf("%0d", $urandom_range(1, 99)));
              send_byte(bad_char());
            end
            2: begin
              send_text($sformatf("%0d", $urandom_range(1, 99)));
              send_byte(CharSpace);
            end
            3: begin
              big = 64'd4294967296 + $urandom_range(0, 1000000);
              send_text($sformatf("%0d", big));
            end
            default: begin
              big = 64'd4294967295 - $urandom_range(0, 10);
              send_text($sformatf("%0d", big));
            end
          endcase
        end else begin
          if ($urandom_range(0, 5) == 0) send_text("00");
          send_text($sformatf("%0d", body_len));
          if (kind == MsgCut && cut_at == 0) begin
            restart_pending = 1'b1;
            return;
          end
        end
        send_crlf();
        if ($urandom_range(0, 9) == 0) begin
          send_text("Content-Length: 99");
          send_crlf();
        end
      end
    end
    if (kind == MsgCut && cut_at == 1) begin
      restart_pending = 1'b1;
      return;
    end
    send_crlf();
    if (kind == MsgSized) begin
      repeat (body_len) send_byte(8'($urandom_range(0, 255)));
    end else if (kind == MsgCut) begin
      repeat ($urandom_range(0, 20)) send_byte(8'($urandom_range(0, 255)));
      restart_pending = 1'b1;
    end
  endtask

  initial begin : pop_side
    pop_mode_e mode;
    forever begin
      mode = pop_mode_e'($urandom_range(0, 3));
      repeat ($urandom_range(16, 160)) begin
        @(posedge clk_i);
        case (mode)
          PopAlways: pop <= 1'b1;
          PopCoin:   pop <= 1'($urandom_range(0, 1));
          PopSparse: pop <= ($urandom_range(0, 4) == 0);
          default:   pop <= ~pop;
        endcase
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    directed_cases();
    while (sent < ItemTarget) random_message();
    push <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("http_response_length_framer regression: pass");
    end else begin
      $display("http_response_length_framer regression: fail");
    end
    $finish;
  end

endmodule
